[rtl/core/c8_pkg.sv]
// Package for the CHIP-8 instruction core: sizes, request codes,
// beat structs and the hex font table. No dependencies.
package c8_pkg;

  // Sizes (powers of two)
  localparam int MEM_BYTES     = 4096;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int STACK_DEPTH   = 16;

  localparam int MEM_AW  = $clog2(MEM_BYTES);
  localparam int WAW     = $clog2(SCREEN_WIDTH);
  localparam int HAW     = $clog2(SCREEN_HEIGHT);
  localparam int SA_W    = $clog2(STACK_DEPTH);
  localparam int SP_W    = $clog2(STACK_DEPTH + 1);
  localparam int FRAME_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;

  localparam logic [11:0] START_PC  = 12'h200;
  localparam logic [11:0] FONT_BASE = 12'h050;
  localparam int          FONT_LEN  = 80;

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_EXEC  = 2'd1;
  localparam logic [1:0] REQ_PIXEL = 2'd2;
  localparam logic [1:0] REQ_REG   = 2'd3;

  // Opcode groups and special words
  localparam logic [3:0]  OP_SYS  = 4'h0;
  localparam logic [3:0]  OP_JP   = 4'h1;
  localparam logic [3:0]  OP_CALL = 4'h2;
  localparam logic [3:0]  OP_LD   = 4'h6;
  localparam logic [3:0]  OP_ADD  = 4'h7;
  localparam logic [3:0]  OP_LDI  = 4'hA;
  localparam logic [3:0]  OP_DRW  = 4'hD;
  localparam logic [15:0] OPW_CLS = 16'h00E0;
  localparam logic [15:0] OPW_RET = 16'h00EE;

  localparam logic [7:0] FONT [FONT_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] address;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic [11:0] pc_after;
    logic [15:0] fetched_opcode;
    logic [7:0]  read_data;
    logic        collision;
    logic        stack_fault;
  } out_t;

endpackage

[rtl/core/chip8_instruction_core.sv]
// CHIP-8 subset core: sequencer around program, frame, register and
// stack memories. Depends on c8_pkg and c8_ram.
//
// Usage: one input beat (in_valid/in_stall, in_data) is one request:
// write a program byte, execute one instruction, read a pixel or read a
// V register. Each request gives exactly one result beat on
// out_valid/out_stall/out_data, in order.
// From accept: a write goes to S_DONE, a pixel or register read through
// S_RPIX or S_RREG, an instruction through S_F1, S_F2 and S_EXEC, then S_RET
// for RET, S_CLS per row for CLS, or S_DY then S_DREQ/S_DWAIT per sprite row
// for DXYN (rows clipped at the bottom edge). One request is in flight at a
// time; the next is taken once the result sits in the output register, where
// a stalled result holds its payload until taken while the next request is
// already at work. The draw loop (one program-memory read plus one frame-row
// read-modify-write per sprite row) and CLS are the longest. After reset a
// clearing pass over all MEM_BYTES (4096) addresses loads the font, zeroes
// program memory, the frame rows and V0..VF; in_stall stays high during it.
module chip8_instruction_core
  import c8_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_F1, S_F2, S_EXEC, S_RET, S_CLS,
    S_DY, S_DREQ, S_DWAIT, S_RPIX, S_RREG, S_DONE
  } state_t;

  localparam int YW = HAW + 5;

  state_t            state_r;
  logic [MEM_AW-1:0] clr_cnt_r;
  logic [11:0]       pc_r, i_r;
  logic [SP_W-1:0]   sp_r;
  in_t               req_r;
  logic [15:0]       op_r;
  logic [7:0]        rd_r;
  logic              coll_r, fault_r;
  logic [WAW-1:0]    x0_r;
  logic [HAW-1:0]    y0_r, row_r;
  logic [4:0]        r_r;
  logic [HAW-1:0]    cls_cnt_r;
  logic              out_valid_r;
  out_t              out_r;

  // Memory ports
  logic              pm_we;
  logic [MEM_AW-1:0] pm_waddr, pm_raddr;
  logic [7:0]        pm_wdata, pm_rdata;
  logic              fb_we;
  logic [HAW-1:0]    fb_waddr, fb_raddr;
  logic [SCREEN_WIDTH-1:0] fb_wdata, fb_rdata;
  logic              vr_we;
  logic [3:0]        vr_waddr, vr_raddr;
  logic [7:0]        vr_wdata, vr_rdata;
  logic              st_we;
  logic [SA_W-1:0]   st_waddr, st_raddr;
  logic [11:0]       st_wdata, st_rdata;

  c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_pmem (
    .clk, .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(pm_raddr), .rdata(pm_rdata));
  c8_ram #(.WIDTH(SCREEN_WIDTH), .DEPTH(SCREEN_HEIGHT)) u_frame (
    .clk, .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
    .raddr(fb_raddr), .rdata(fb_rdata));
  c8_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
    .clk, .we(vr_we), .waddr(vr_waddr), .wdata(vr_wdata),
    .raddr(vr_raddr), .rdata(vr_rdata));
  c8_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata));

  logic accept;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Derived values
  logic [11:0]       pc_inc1, pc_inc2, spr_addr;
  logic [YW-1:0]     y_sum;
  logic [13:0]       pix_idx;
  logic [SCREEN_WIDTH-1:0] spr_mask;
  logic [11:0]       font_off;
  logic              done_go;

  assign pc_inc1  = pc_r + 12'd1;
  assign pc_inc2  = pc_r + 12'd2;
  assign spr_addr = i_r + {7'd0, r_r};
  assign y_sum    = YW'(y0_r) + YW'(r_r);
  assign pix_idx  = {2'b00, in_data.address};
  assign font_off = 12'(clr_cnt_r) - FONT_BASE;
  assign done_go  = !out_valid_r || !out_stall;

  // Sprite byte placed at x0, clipped at the right edge
  always_comb begin
    logic [WAW:0] xx, d;
    for (int x = 0; x < SCREEN_WIDTH; x++) begin
      xx = (WAW+1)'(x);
      d  = xx - {1'b0, x0_r};
      spr_mask[x] = (xx >= {1'b0, x0_r}) && (d < (WAW+1)'(8)) &&
                    pm_rdata[3'(3'd7 - d[2:0])];
    end
  end

  // Memory port control
  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = in_data.address[MEM_AW-1:0];
    pm_wdata = in_data.write_data;
    pm_raddr = pc_r[MEM_AW-1:0];
    fb_we    = 1'b0;
    fb_waddr = row_r;
    fb_wdata = fb_rdata ^ spr_mask;
    fb_raddr = y_sum[HAW-1:0];
    vr_we    = 1'b0;
    vr_waddr = op_r[11:8];
    vr_wdata = op_r[7:0];
    vr_raddr = op_r[7:4];
    st_we    = 1'b0;
    st_waddr = sp_r[SA_W-1:0];
    st_wdata = pc_r;
    st_raddr = SA_W'(sp_r - SP_W'(1));
    case (state_r)
      S_CLEAR: begin
        pm_we    = 1'b1;
        pm_waddr = clr_cnt_r;
        pm_wdata = (12'(clr_cnt_r) >= FONT_BASE && font_off < 12'(FONT_LEN)) ?
                   FONT[7'(font_off)] : 8'd0;
        fb_we    = clr_cnt_r < MEM_AW'(SCREEN_HEIGHT);
        fb_waddr = clr_cnt_r[HAW-1:0];
        fb_wdata = '0;
        vr_we    = clr_cnt_r < MEM_AW'(16);
        vr_waddr = clr_cnt_r[3:0];
        vr_wdata = 8'd0;
      end
      S_IDLE: begin
        pm_we    = accept && in_data.req_type == REQ_WRITE &&
                   (in_data.address >> MEM_AW) == 12'd0;
        fb_raddr = pix_idx[WAW+HAW-1:WAW];
        vr_raddr = in_data.address[3:0];
      end
      S_F1: pm_raddr = pc_inc1[MEM_AW-1:0];
      S_F2: vr_raddr = op_r[11:8];
      S_EXEC: begin
        case (op_r[15:12])
          OP_LD:   vr_we = 1'b1;
          OP_ADD: begin
            vr_we    = 1'b1;
            vr_wdata = vr_rdata + op_r[7:0];
          end
          OP_CALL: st_we = (sp_r < SP_W'(STACK_DEPTH));
          default: ;
        endcase
      end
      S_CLS: begin
        fb_we    = 1'b1;
        fb_waddr = cls_cnt_r;
        fb_wdata = '0;
      end
      S_DREQ: begin
        pm_raddr = spr_addr[MEM_AW-1:0];
        if (r_r == {1'b0, op_r[3:0]} || y_sum >= YW'(SCREEN_HEIGHT)) begin
          vr_we    = 1'b1;
          vr_waddr = 4'hF;
          vr_wdata = {7'd0, coll_r};
        end
      end
      S_DWAIT: fb_we = 1'b1;
      default: ;
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pc_r        <= START_PC;
      i_r         <= 12'd0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
          if (clr_cnt_r == MEM_AW'(MEM_BYTES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            req_r   <= in_data;
            op_r    <= 16'd0;
            rd_r    <= 8'd0;
            coll_r  <= 1'b0;
            fault_r <= 1'b0;
            case (in_data.req_type)
              REQ_WRITE: state_r <= S_DONE;
              REQ_EXEC:  state_r <= S_F1;
              REQ_PIXEL: state_r <= S_RPIX;
              default:   state_r <= S_RREG;
            endcase
          end
        end
        S_F1: begin
          op_r[15:8] <= pm_rdata;
          state_r    <= S_F2;
        end
        S_F2: begin
          op_r[7:0] <= pm_rdata;
          pc_r      <= pc_inc2;
          state_r   <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_DONE;
          case (op_r[15:12])
            OP_SYS: begin
              if (op_r == OPW_CLS) begin
                cls_cnt_r <= '0;
                state_r   <= S_CLS;
              end else if (op_r == OPW_RET) begin
                if (sp_r == '0) begin
                  fault_r <= 1'b1;
                end else begin
                  sp_r    <= sp_r - SP_W'(1);
                  state_r <= S_RET;
                end
              end
            end
            OP_JP: pc_r <= op_r[11:0];
            OP_CALL: begin
              if (sp_r >= SP_W'(STACK_DEPTH)) begin
                fault_r <= 1'b1;
              end else begin
                sp_r <= sp_r + SP_W'(1);
                pc_r <= op_r[11:0];
              end
            end
            OP_LDI: i_r <= op_r[11:0];
            OP_DRW: begin
              x0_r    <= vr_rdata[WAW-1:0];
              state_r <= S_DY;
            end
            default: ;
          endcase
        end
        S_RET: begin
          pc_r    <= st_rdata;
          state_r <= S_DONE;
        end
        S_CLS: begin
          cls_cnt_r <= cls_cnt_r + HAW'(1);
          if (cls_cnt_r == HAW'(SCREEN_HEIGHT - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DY: begin
          y0_r    <= vr_rdata[HAW-1:0];
          r_r     <= 5'd0;
          state_r <= S_DREQ;
        end
        S_DREQ: begin
          if (r_r == {1'b0, op_r[3:0]} || y_sum >= YW'(SCREEN_HEIGHT)) begin
            state_r <= S_DONE;
          end else begin
            row_r   <= y_sum[HAW-1:0];
            state_r <= S_DWAIT;
          end
        end
        S_DWAIT: begin
          coll_r  <= coll_r | (|(fb_rdata & spr_mask));
          r_r     <= r_r + 5'd1;
          state_r <= S_DREQ;
        end
        S_RPIX: begin
          rd_r    <= ({2'b00, req_r.address} < 14'(FRAME_SIZE)) ?
                     {7'd0, fb_rdata[req_r.address[WAW-1:0]]} : 8'd0;
          state_r <= S_DONE;
        end
        S_RREG: begin
          rd_r    <= vr_rdata;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (done_go) begin
            out_valid_r          <= 1'b1;
            out_r.pc_after       <= pc_r;
            out_r.fetched_opcode <= op_r;
            out_r.read_data      <= rd_r;
            out_r.collision      <= coll_r;
            out_r.stack_fault    <= fault_r;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/c8_ram.sv]
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/c8_checker.sv]
// Port-level checker for chip8_instruction_core, bound to the top level.
// Depends on c8_pkg.
module c8_checker
  import c8_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Clearing pass blocks requests right after reset
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request taken during clearing pass");

  // One request at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // Collision only comes from a draw
  a_coll_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.collision |-> out_data.fetched_opcode[15:12] == OP_DRW)
    else $error("collision without draw");

  // Stack fault only from CALL or RET
  a_fault_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stack_fault |->
      out_data.fetched_opcode[15:12] == OP_CALL ||
      out_data.fetched_opcode == OPW_RET)
    else $error("stack fault without call or return");

endmodule

bind chip8_instruction_core c8_checker u_c8_checker (
  .clk, .rst_n, .in_valid, .in_stall,
  .out_valid, .out_stall, .out_data
);
